// File: rtl/core/tci_pkg.sv
// ----------------------------------------------------------------------------
// tci_pkg
// Shared types, widths and helpers of the trilinear cell interpolator.
// ----------------------------------------------------------------------------
`default_nettype none

package tci_pkg;

  localparam int unsigned NODE_DEPTH_DEF = 4096;
  localparam int unsigned CELL_DEPTH_DEF = 1024;
  localparam int unsigned CORNERS        = 8;

  localparam int unsigned OP_W    = 2;
  localparam int unsigned NODE_W  = 12;
  localparam int unsigned CELL_W  = 10;
  localparam int unsigned SLOT_W  = 3;
  localparam int unsigned POS_W   = 32;
  localparam int unsigned COEF_W  = 17;
  localparam int unsigned FRAC_W  = 16;

  localparam int unsigned MA_W    = 34;
  localparam int unsigned MB_W    = 18;
  localparam int unsigned PROD_W  = MA_W + MB_W;
  localparam int unsigned ACC_W   = 50;
  localparam int unsigned WLO     = 2 * FRAC_W;

  localparam logic [COEF_W-1:0] ONE_Q16 = COEF_W'(1 << FRAC_W);

  typedef enum logic [OP_W-1:0] {
    OP_WR_NODE   = 2'd0,
    OP_WR_CORNER = 2'd1,
    OP_QUERY     = 2'd2,
    OP_NONE      = 2'd3
  } opcode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_AB,
    ST_MUL_ABC,
    ST_MUL_X,
    ST_MUL_Y,
    ST_MUL_Z,
    ST_FLUSH,
    ST_OUT
  } state_e;

  typedef enum logic [2:0] {
    MOP_AB,
    MOP_ABC,
    MOP_X,
    MOP_Y,
    MOP_Z
  } mop_e;

  typedef struct packed {
    logic              clr;
    logic              mul_en;
    mop_e              op;
    logic [SLOT_W-1:0] corner;
    logic              node_ok;
    logic              load;
  } mac_ctrl_t;

  function automatic logic [COEF_W-1:0] clamp_coef(input logic [COEF_W-1:0] c);
    clamp_coef = (c > ONE_Q16) ? ONE_Q16 : c;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/tci_ram.sv
// ----------------------------------------------------------------------------
// tci_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tci_ram
  import tci_pkg::*;
#(
  parameter int unsigned WIDTH = POS_W,
  parameter int unsigned DEPTH = NODE_DEPTH_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: rtl/core/tci_mac.sv
// ----------------------------------------------------------------------------
// tci_mac
// Shared 34x18 signed multiplier with weight build-up and three accumulators.
// ----------------------------------------------------------------------------
`default_nettype none

module tci_mac
  import tci_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire mac_ctrl_t               ctrl_i,
  input  wire logic [COEF_W-1:0]       coef_u_i,
  input  wire logic [COEF_W-1:0]       coef_v_i,
  input  wire logic [COEF_W-1:0]       coef_w_i,
  input  wire logic [POS_W-1:0]        pos_x_i,
  input  wire logic [POS_W-1:0]        pos_y_i,
  input  wire logic [POS_W-1:0]        pos_z_i,
  output logic      [POS_W-1:0]        interp_x_o,
  output logic      [POS_W-1:0]        interp_y_o,
  output logic      [POS_W-1:0]        interp_z_o
);

  logic [COEF_W-1:0]        cu_q, cv_q, cw_q;
  logic [COEF_W-1:0]        wt_q;
  logic signed [PROD_W-1:0] prod_q, prod_d;
  logic signed [ACC_W-1:0]  acc_x_q, acc_y_q, acc_z_q;
  logic signed [ACC_W-1:0]  acc_cur, acc_sum;
  logic [POS_W-1:0]         res_x_q, res_y_q, res_z_q;
  logic                     acc_en_q, acc_en_d;
  mop_e                     acc_sel_q;

  logic [COEF_W-1:0]        fa, fb, fc;
  logic [COEF_W-1:0]        wt_new;
  logic signed [MA_W-1:0]   ma;
  logic signed [MB_W-1:0]   mb;
  logic [POS_W-1:0]         pos_sel;

  assign fa     = ctrl_i.corner[0] ? cu_q : ONE_Q16 - cu_q;
  assign fb     = ctrl_i.corner[1] ? cv_q : ONE_Q16 - cv_q;
  assign fc     = ctrl_i.corner[2] ? cw_q : ONE_Q16 - cw_q;
  assign wt_new = prod_q[WLO+COEF_W-1:WLO];

  always_comb begin
    pos_sel = '0;
    ma      = '0;
    mb      = '0;
    unique case (ctrl_i.op)
      MOP_AB: begin
        ma = MA_W'(fa);
        mb = MB_W'(fb);
      end
      MOP_ABC: begin
        ma = prod_q[MA_W-1:0];
        mb = MB_W'(fc);
      end
      MOP_X: begin
        pos_sel = pos_x_i;
        mb      = MB_W'(wt_new);
      end
      MOP_Y: begin
        pos_sel = pos_y_i;
        mb      = MB_W'(wt_q);
      end
      MOP_Z: begin
        pos_sel = pos_z_i;
        mb      = MB_W'(wt_q);
      end
      default: begin
        ma = '0;
      end
    endcase
    if (ctrl_i.op == MOP_X || ctrl_i.op == MOP_Y || ctrl_i.op == MOP_Z) begin
      ma = ctrl_i.node_ok ? MA_W'($signed(pos_sel)) : '0;
    end
  end

  assign prod_d   = ma * mb;
  assign acc_en_d = ctrl_i.mul_en &&
                    (ctrl_i.op == MOP_X || ctrl_i.op == MOP_Y || ctrl_i.op == MOP_Z);

  always_comb begin
    case (acc_sel_q)
      MOP_Y:   acc_cur = acc_y_q;
      MOP_Z:   acc_cur = acc_z_q;
      default: acc_cur = acc_x_q;
    endcase
  end

  assign acc_sum = acc_cur + ACC_W'(prod_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_en_q <= 1'b0;
    end else if (ctrl_i.clr) begin
      acc_en_q <= 1'b0;
    end else begin
      acc_en_q <= acc_en_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      prod_q    <= prod_d;
      acc_sel_q <= ctrl_i.op;
    end
    if (ctrl_i.mul_en && ctrl_i.op == MOP_X) begin
      wt_q <= wt_new;
    end
    if (ctrl_i.clr) begin
      cu_q    <= clamp_coef(coef_u_i);
      cv_q    <= clamp_coef(coef_v_i);
      cw_q    <= clamp_coef(coef_w_i);
      acc_x_q <= '0;
      acc_y_q <= '0;
      acc_z_q <= '0;
    end else if (acc_en_q) begin
      case (acc_sel_q)
        MOP_Y:   acc_y_q <= acc_sum;
        MOP_Z:   acc_z_q <= acc_sum;
        default: acc_x_q <= acc_sum;
      endcase
    end
    if (ctrl_i.load) begin
      res_x_q <= acc_x_q[FRAC_W+POS_W-1:FRAC_W];
      res_y_q <= acc_y_q[FRAC_W+POS_W-1:FRAC_W];
      res_z_q <= acc_z_q[FRAC_W+POS_W-1:FRAC_W];
    end
  end

  assign interp_x_o = res_x_q;
  assign interp_y_o = res_y_q;
  assign interp_z_o = res_z_q;

endmodule

`default_nettype wire

// File: rtl/core/tci_ctrl.sv
// ----------------------------------------------------------------------------
// tci_ctrl
// Sequencer: store writes, corner walk, memory ports and output handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module tci_ctrl
  import tci_pkg::*;
#(
  parameter int unsigned NODE_DEPTH = NODE_DEPTH_DEF,
  parameter int unsigned CELL_DEPTH = CELL_DEPTH_DEF,
  localparam int unsigned NAW = $clog2(NODE_DEPTH),
  localparam int unsigned TAW = $clog2(CELL_DEPTH * CORNERS)
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              s_valid_i,
  input  wire logic [OP_W-1:0]   opcode_i,
  input  wire logic [NODE_W-1:0] node_index_i,
  input  wire logic [CELL_W-1:0] cell_index_i,
  input  wire logic [SLOT_W-1:0] corner_slot_i,
  input  wire logic [NODE_W-1:0] tbl_rdata_i,
  input  wire logic              m_ready_i,
  output logic                   s_ready_o,
  output logic                   m_valid_o,
  output logic                   tbl_we_o,
  output logic                   tbl_re_o,
  output logic      [TAW-1:0]    tbl_addr_o,
  output logic                   pos_we_o,
  output logic                   pos_re_o,
  output logic      [NAW-1:0]    pos_addr_o,
  output mac_ctrl_t              mac_o
);

  state_e            state_q, state_d;
  logic [SLOT_W-1:0] corner_q, corner_d;
  logic [CELL_W-1:0] cell_q;
  logic              cell_ok_q;
  logic              node_ok_q;
  logic              m_valid_q, m_valid_d;
  logic              accept;
  logic              cell_in_ok;
  logic              node_in_ok;
  logic [NODE_W-1:0] node_sel;
  opcode_e           op;

  assign op         = opcode_e'(opcode_i);
  assign s_ready_o  = (state_q == ST_IDLE);
  assign accept     = s_valid_i && s_ready_o;
  assign cell_in_ok = 32'(cell_index_i) < 32'(CELL_DEPTH);
  assign node_in_ok = 32'(node_index_i) < 32'(NODE_DEPTH);
  assign node_sel   = cell_ok_q ? tbl_rdata_i : '0;

  assign tbl_we_o   = accept && op == OP_WR_CORNER && cell_in_ok;
  assign tbl_re_o   = (state_q == ST_MUL_AB);
  assign tbl_addr_o = tbl_we_o ? TAW'({cell_index_i, corner_slot_i}) : TAW'({cell_q, corner_q});
  assign pos_we_o   = accept && op == OP_WR_NODE && node_in_ok;
  assign pos_re_o   = (state_q == ST_MUL_ABC);
  assign pos_addr_o = pos_we_o ? NAW'(node_index_i) : NAW'(node_sel);
  assign m_valid_o  = m_valid_q;

  always_comb begin
    state_d       = state_q;
    corner_d      = corner_q;
    m_valid_d     = m_valid_q && !m_ready_i;
    mac_o.clr     = 1'b0;
    mac_o.mul_en  = 1'b0;
    mac_o.op      = MOP_AB;
    mac_o.corner  = corner_q;
    mac_o.node_ok = node_ok_q;
    mac_o.load    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (op)
            OP_QUERY: begin
              state_d   = ST_MUL_AB;
              corner_d  = '0;
              mac_o.clr = 1'b1;
            end
            OP_WR_NODE, OP_WR_CORNER, OP_NONE: begin
              state_d = ST_IDLE;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_MUL_AB: begin
        mac_o.mul_en = 1'b1;
        mac_o.op     = MOP_AB;
        state_d      = ST_MUL_ABC;
      end
      ST_MUL_ABC: begin
        mac_o.mul_en = 1'b1;
        mac_o.op     = MOP_ABC;
        state_d      = ST_MUL_X;
      end
      ST_MUL_X: begin
        mac_o.mul_en = 1'b1;
        mac_o.op     = MOP_X;
        state_d      = ST_MUL_Y;
      end
      ST_MUL_Y: begin
        mac_o.mul_en = 1'b1;
        mac_o.op     = MOP_Y;
        state_d      = ST_MUL_Z;
      end
      ST_MUL_Z: begin
        mac_o.mul_en = 1'b1;
        mac_o.op     = MOP_Z;
        if (corner_q == SLOT_W'(CORNERS - 1)) begin
          state_d = ST_FLUSH;
        end else begin
          corner_d = corner_q + SLOT_W'(1);
          state_d  = ST_MUL_AB;
        end
      end
      ST_FLUSH: begin
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!m_valid_q || m_ready_i) begin
          mac_o.load = 1'b1;
          m_valid_d  = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      corner_q  <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      corner_q  <= corner_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && op == OP_QUERY) begin
      cell_q    <= cell_index_i;
      cell_ok_q <= cell_in_ok;
    end
    if (state_q == ST_MUL_ABC) begin
      node_ok_q <= 32'(node_sel) < 32'(NODE_DEPTH);
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/trilinear_cell_interpolator_core.sv
// ----------------------------------------------------------------------------
// trilinear_cell_interpolator_core
// Node position store, cell corner table and trilinear blend of eight corners.
// ----------------------------------------------------------------------------
//  Channel  | Direction | tuser       | tdata
//  s_axis   | in        | opcode      | node_index .. coef_w, 184 bits
//  m_axis   | out       | -           | interp_x, interp_y, interp_z, 96 bits
//
//  Write transactions (node position, cell corner) leave the core idle and ready.
//  A query runs five passes per corner through the shared 34x18 multiplier
//  over eight corners, then a flush and the load of the output register; the
//  next transaction is accepted once the core is back in idle after the load.
//  The stores are not cleared after reset; no clearing pass is run.
//  A held result stalls only the final load of the next query.
// ----------------------------------------------------------------------------
`default_nettype none

module trilinear_cell_interpolator_core
  import tci_pkg::*;
#(
  parameter int unsigned NODE_DEPTH = NODE_DEPTH_DEF,
  parameter int unsigned CELL_DEPTH = CELL_DEPTH_DEF
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           s_axis_tvalid,
  output logic                s_axis_tready,
  // node_index[11:0] pos_x[43:12] pos_y[75:44] pos_z[107:76] cell_index[117:108]
  // corner_slot[120:118] corner_node[132:121] coef_u[149:133] coef_v[166:150]
  // coef_w[183:167]
  input  wire logic [183:0]   s_axis_tdata,
  // opcode[1:0]
  input  wire logic [OP_W-1:0] s_axis_tuser,
  output logic                m_axis_tvalid,
  input  wire logic           m_axis_tready,
  // interp_x[31:0] interp_y[63:32] interp_z[95:64]
  output logic      [95:0]    m_axis_tdata
);

  localparam int unsigned NAW = $clog2(NODE_DEPTH);
  localparam int unsigned TAW = $clog2(CELL_DEPTH * CORNERS);

  logic [NODE_W-1:0] node_index;
  logic [POS_W-1:0]  pos_x, pos_y, pos_z;
  logic [CELL_W-1:0] cell_index;
  logic [SLOT_W-1:0] corner_slot;
  logic [NODE_W-1:0] corner_node;
  logic [COEF_W-1:0] coef_u, coef_v, coef_w;

  logic              tbl_we, tbl_re, pos_we, pos_re;
  logic [TAW-1:0]    tbl_addr;
  logic [NAW-1:0]    pos_addr;
  logic [NODE_W-1:0] tbl_rdata;
  logic [POS_W-1:0]  rd_x, rd_y, rd_z;
  logic [POS_W-1:0]  interp_x, interp_y, interp_z;
  mac_ctrl_t         mac_ctrl;

  assign node_index  = s_axis_tdata[11:0];
  assign pos_x       = s_axis_tdata[43:12];
  assign pos_y       = s_axis_tdata[75:44];
  assign pos_z       = s_axis_tdata[107:76];
  assign cell_index  = s_axis_tdata[117:108];
  assign corner_slot = s_axis_tdata[120:118];
  assign corner_node = s_axis_tdata[132:121];
  assign coef_u      = s_axis_tdata[149:133];
  assign coef_v      = s_axis_tdata[166:150];
  assign coef_w      = s_axis_tdata[183:167];

  tci_ctrl #(
    .NODE_DEPTH (NODE_DEPTH),
    .CELL_DEPTH (CELL_DEPTH)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_valid_i     (s_axis_tvalid),
    .opcode_i      (s_axis_tuser),
    .node_index_i  (node_index),
    .cell_index_i  (cell_index),
    .corner_slot_i (corner_slot),
    .tbl_rdata_i   (tbl_rdata),
    .m_ready_i     (m_axis_tready),
    .s_ready_o     (s_axis_tready),
    .m_valid_o     (m_axis_tvalid),
    .tbl_we_o      (tbl_we),
    .tbl_re_o      (tbl_re),
    .tbl_addr_o    (tbl_addr),
    .pos_we_o      (pos_we),
    .pos_re_o      (pos_re),
    .pos_addr_o    (pos_addr),
    .mac_o         (mac_ctrl)
  );

  tci_ram #(
    .WIDTH (NODE_W),
    .DEPTH (CELL_DEPTH * CORNERS)
  ) u_corner_ram (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .re_i    (tbl_re),
    .addr_i  (tbl_addr),
    .wdata_i (corner_node),
    .rdata_o (tbl_rdata)
  );

  tci_ram #(
    .WIDTH (POS_W),
    .DEPTH (NODE_DEPTH)
  ) u_node_x_ram (
    .clk_i   (clk_i),
    .we_i    (pos_we),
    .re_i    (pos_re),
    .addr_i  (pos_addr),
    .wdata_i (pos_x),
    .rdata_o (rd_x)
  );

  tci_ram #(
    .WIDTH (POS_W),
    .DEPTH (NODE_DEPTH)
  ) u_node_y_ram (
    .clk_i   (clk_i),
    .we_i    (pos_we),
    .re_i    (pos_re),
    .addr_i  (pos_addr),
    .wdata_i (pos_y),
    .rdata_o (rd_y)
  );

  tci_ram #(
    .WIDTH (POS_W),
    .DEPTH (NODE_DEPTH)
  ) u_node_z_ram (
    .clk_i   (clk_i),
    .we_i    (pos_we),
    .re_i    (pos_re),
    .addr_i  (pos_addr),
    .wdata_i (pos_z),
    .rdata_o (rd_z)
  );

  tci_mac u_mac (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (mac_ctrl),
    .coef_u_i   (coef_u),
    .coef_v_i   (coef_v),
    .coef_w_i   (coef_w),
    .pos_x_i    (rd_x),
    .pos_y_i    (rd_y),
    .pos_z_i    (rd_z),
    .interp_x_o (interp_x),
    .interp_y_o (interp_y),
    .interp_z_o (interp_z)
  );

  assign m_axis_tdata = {interp_z, interp_y, interp_x};

endmodule

`default_nettype wire

// File: tb/trilinear_blend_checker.sv
// ----------------------------------------------------------------------------
// trilinear_blend_checker
// Watches both stream channels of the interpolator core. It keeps a shadow of
// the node position store and the cell corner table, computes the blended
// position for every accepted query, and compares each output transaction
// field by field against the oldest pending blend.
// ----------------------------------------------------------------------------
module trilinear_blend_checker
  import tci_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_tvalid_i,
  input  logic            s_tready_i,
  input  logic [183:0]    s_tdata_i,
  input  logic [OP_W-1:0] s_tuser_i,
  input  logic            m_tvalid_i,
  input  logic            m_tready_i,
  input  logic [95:0]     m_tdata_i,
  output int              fail_count_o,
  output int              pending_o
);

  logic [POS_W-1:0]  node_x_mem [NODE_DEPTH_DEF];
  logic [POS_W-1:0]  node_y_mem [NODE_DEPTH_DEF];
  logic [POS_W-1:0]  node_z_mem [NODE_DEPTH_DEF];
  logic [NODE_W-1:0] corner_mem [CELL_DEPTH_DEF * CORNERS];
  logic [95:0]       blend_fifo [$];
  logic [95:0]       want;

  function automatic logic [95:0] blend_cell(input logic [CELL_W-1:0] cell_id,
                                             input logic [COEF_W-1:0] u,
                                             input logic [COEF_W-1:0] v,
                                             input logic [COEF_W-1:0] w);
    logic [COEF_W-1:0] cu, cv, cw, fu, fv, fw;
    logic [63:0]       weight;
    logic [NODE_W-1:0] node;
    longint            sum_x, sum_y, sum_z;
    cu = (u > ONE_Q16) ? ONE_Q16 : u;
    cv = (v > ONE_Q16) ? ONE_Q16 : v;
    cw = (w > ONE_Q16) ? ONE_Q16 : w;
    sum_x = 0;
    sum_y = 0;
    sum_z = 0;
    for (int k = 0; k < CORNERS; k++) begin
      node   = corner_mem[{cell_id, 3'(k)}];
      fu     = (k & 1) ? cu : ONE_Q16 - cu;
      fv     = (k & 2) ? cv : ONE_Q16 - cv;
      fw     = (k & 4) ? cw : ONE_Q16 - cw;
      weight = (64'(fu) * 64'(fv) * 64'(fw)) >> 32;
      sum_x += longint'($signed(node_x_mem[node])) * longint'(weight);
      sum_y += longint'($signed(node_y_mem[node])) * longint'(weight);
      sum_z += longint'($signed(node_z_mem[node])) * longint'(weight);
    end
    sum_x = sum_x >>> FRAC_W;
    sum_y = sum_y >>> FRAC_W;
    sum_z = sum_z >>> FRAC_W;
    return {sum_z[31:0], sum_y[31:0], sum_x[31:0]};
  endfunction

  task automatic check_field(input string name, input logic [31:0] exp_val,
                             input logic [31:0] got_val);
    if (got_val !== exp_val) begin
      $error("%s: expected %0d, got %0d", name, $signed(exp_val), $signed(got_val));
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_tvalid_i && m_tready_i) begin
        if (blend_fifo.size() == 0) begin
          $error("unexpected result transaction: %h", m_tdata_i);
          fail_count_o++;
        end else begin
          want = blend_fifo.pop_front();
          check_field("interp_x", want[31:0],  m_tdata_i[31:0]);
          check_field("interp_y", want[63:32], m_tdata_i[63:32]);
          check_field("interp_z", want[95:64], m_tdata_i[95:64]);
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        case (opcode_e'(s_tuser_i))
          OP_WR_NODE: begin
            node_x_mem[s_tdata_i[11:0]] = s_tdata_i[43:12];
            node_y_mem[s_tdata_i[11:0]] = s_tdata_i[75:44];
            node_z_mem[s_tdata_i[11:0]] = s_tdata_i[107:76];
          end
          OP_WR_CORNER: begin
            corner_mem[{s_tdata_i[117:108], s_tdata_i[120:118]}] = s_tdata_i[132:121];
          end
          OP_QUERY: begin
            blend_fifo.push_back(blend_cell(s_tdata_i[117:108], s_tdata_i[149:133],
                                            s_tdata_i[166:150], s_tdata_i[183:167]));
          end
          default: begin
          end
        endcase
      end
      pending_o = blend_fifo.size();
    end
  end

endmodule

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Stimulus for the trilinear cell interpolator core: loads node positions and
// cell corners, then queries only cells whose corners and nodes are all
// loaded. A directed pass covers extreme positions and coefficients, then
// random well-formed sequences mixed with noise writes and reserved opcodes
// run under bursty input and a stalling output.
// ----------------------------------------------------------------------------
module testbench;
  import tci_pkg::*;

  localparam int ITEM_TARGET = 1800;
  localparam int QUIET_LIMIT = 1000;

  logic            clk_i         = 1'b0;
  logic            rst_ni        = 1'b0;
  logic            s_axis_tvalid = 1'b0;
  logic [183:0]    s_axis_tdata  = '0;
  logic [OP_W-1:0] s_axis_tuser  = '0;
  logic            m_axis_tready = 1'b0;
  logic            s_axis_tready;
  logic            m_axis_tvalid;
  logic [95:0]     m_axis_tdata;
  int              fail_count;
  int              pending;

  logic [NODE_W-1:0] it_node;
  logic [POS_W-1:0]  it_px, it_py, it_pz;
  logic [CELL_W-1:0] it_cell;
  logic [SLOT_W-1:0] it_slot;
  logic [NODE_W-1:0] it_cnode;
  logic [COEF_W-1:0] it_cu, it_cv, it_cw;

  bit                node_set   [NODE_DEPTH_DEF];
  bit                corner_set [CELL_DEPTH_DEF * CORNERS];
  logic [NODE_W-1:0] corner_map [CELL_DEPTH_DEF * CORNERS];
  logic [NODE_W-1:0] written_nodes [$];
  logic [CELL_W-1:0] ready_cells [$];
  int                item_count = 0;
  int                burst_left = 0;
  int                rx_left    = 0;

  trilinear_cell_interpolator_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  trilinear_blend_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tvalid_i   (s_axis_tvalid),
    .s_tready_i   (s_axis_tready),
    .s_tdata_i    (s_axis_tdata),
    .s_tuser_i    (s_axis_tuser),
    .m_tvalid_i   (m_axis_tvalid),
    .m_tready_i   (m_axis_tready),
    .m_tdata_i    (m_axis_tdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always #6 clk_i = ~clk_i;

  // alternate ready runs and stall runs of random length
  always @(negedge clk_i) begin
    if (rx_left == 0) begin
      m_axis_tready = !m_axis_tready;
      if (m_axis_tready) begin
        rx_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(0, 24);
      end else begin
        rx_left = $urandom_range(0, 9);
      end
    end else begin
      rx_left--;
    end
  end

  function automatic logic [POS_W-1:0] rand_pos();
    case ($urandom_range(0, 7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'($urandom_range(0, 65535));
      3: return 32'h0 - 32'($urandom_range(0, 65535));
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [COEF_W-1:0] rand_coef();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return ONE_Q16;
      2: return COEF_W'($urandom_range(65537, 131071));
      default: return COEF_W'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [NODE_W-1:0] pick_node();
    return written_nodes[$urandom_range(0, written_nodes.size() - 1)];
  endfunction

  function automatic bit cell_ready(input logic [CELL_W-1:0] cell_id);
    for (int k = 0; k < CORNERS; k++) begin
      if (!corner_set[{cell_id, 3'(k)}]) return 1'b0;
      if (!node_set[corner_map[{cell_id, 3'(k)}]]) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic scramble_fields();
    it_node  = NODE_W'($urandom());
    it_px    = $urandom();
    it_py    = $urandom();
    it_pz    = $urandom();
    it_cell  = CELL_W'($urandom());
    it_slot  = SLOT_W'($urandom());
    it_cnode = NODE_W'($urandom());
    it_cu    = COEF_W'($urandom_range(0, 131071));
    it_cv    = COEF_W'($urandom_range(0, 131071));
    it_cw    = COEF_W'($urandom_range(0, 131071));
  endtask

  task automatic send_item(input opcode_e op);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 10);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      repeat (gap) begin
        @(negedge clk_i);
        s_axis_tvalid = 1'b0;
      end
    end
    burst_left--;
    @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = op;
    s_axis_tdata  = {it_cw, it_cv, it_cu, it_cnode, it_slot, it_cell,
                     it_pz, it_py, it_px, it_node};
    do @(posedge clk_i); while (!s_axis_tready);
    if (op != OP_NONE) item_count++;
  endtask

  task automatic put_node(input logic [NODE_W-1:0] idx, input logic [POS_W-1:0] x,
                          input logic [POS_W-1:0] y, input logic [POS_W-1:0] z);
    scramble_fields();
    it_node = idx;
    it_px   = x;
    it_py   = y;
    it_pz   = z;
    send_item(OP_WR_NODE);
    node_set[idx] = 1'b1;
    written_nodes.push_back(idx);
  endtask

  task automatic put_corner(input logic [CELL_W-1:0] cell_id, input logic [SLOT_W-1:0] slot,
                            input logic [NODE_W-1:0] node);
    scramble_fields();
    it_cell  = cell_id;
    it_slot  = slot;
    it_cnode = node;
    send_item(OP_WR_CORNER);
    corner_set[{cell_id, slot}] = 1'b1;
    corner_map[{cell_id, slot}] = node;
  endtask

  task automatic ask(input logic [CELL_W-1:0] cell_id, input logic [COEF_W-1:0] u,
                     input logic [COEF_W-1:0] v, input logic [COEF_W-1:0] w);
    scramble_fields();
    it_cell = cell_id;
    it_cu   = u;
    it_cv   = v;
    it_cw   = w;
    send_item(OP_QUERY);
  endtask

  task automatic send_reserved();
    scramble_fields();
    send_item(OP_NONE);
  endtask

  // hold the input idle until every pending blend has come out
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("trilinear_cell_interpolator_core: mismatch");
    $finish;
  end

  initial begin : stimulus
    logic [CELL_W-1:0] cell_id;
    bit                drained;
    drained = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    put_node(12'd0,    32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000);
    put_node(12'd1,    32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    put_node(12'd2,    32'h0001_0000, 32'hFFFF_0000, 32'h0000_0001);
    put_node(12'd3,    32'hFFFF_FFFF, 32'h0000_0000, 32'h7FFF_FFFF);
    put_node(12'd4095, 32'h1234_5678, 32'h8765_4321, 32'h8000_0000);
    put_corner(10'd0, 3'd0, 12'd0);
    put_corner(10'd0, 3'd1, 12'd1);
    put_corner(10'd0, 3'd2, 12'd2);
    put_corner(10'd0, 3'd3, 12'd3);
    put_corner(10'd0, 3'd4, 12'd4095);
    put_corner(10'd0, 3'd5, 12'd0);
    put_corner(10'd0, 3'd6, 12'd1);
    put_corner(10'd0, 3'd7, 12'd2);
    ready_cells.push_back(10'd0);
    ask(10'd0, 17'd0, 17'd0, 17'd0);
    ask(10'd0, ONE_Q16, ONE_Q16, ONE_Q16);
    ask(10'd0, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF);
    ask(10'd0, 17'd32768, 17'd32768, 17'd32768);
    ask(10'd0, ONE_Q16, 17'd0, 17'd32768);
    ask(10'd0, 17'd1, 17'd65535, 17'd65537);
    send_reserved();

    while (item_count < ITEM_TARGET) begin
      if (!drained && item_count >= ITEM_TARGET / 2) begin
        drain();
        drained = 1'b1;
      end
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          cell_id = CELL_W'($urandom_range(0, 1023));
          repeat ($urandom_range(0, 3)) begin
            put_node(NODE_W'($urandom_range(0, 4095)), rand_pos(), rand_pos(), rand_pos());
          end
          for (int k = 0; k < CORNERS; k++) put_corner(cell_id, 3'(k), pick_node());
          ready_cells.push_back(cell_id);
          repeat ($urandom_range(1, 4)) ask(cell_id, rand_coef(), rand_coef(), rand_coef());
        end
        6: begin
          cell_id = ready_cells[$urandom_range(0, ready_cells.size() - 1)];
          put_corner(cell_id, SLOT_W'($urandom_range(0, 7)), pick_node());
          if (cell_ready(cell_id)) ask(cell_id, rand_coef(), rand_coef(), rand_coef());
        end
        7: put_node(NODE_W'($urandom_range(0, 4095)), rand_pos(), rand_pos(), rand_pos());
        8: put_corner(CELL_W'($urandom_range(0, 1023)), SLOT_W'($urandom_range(0, 7)),
                      NODE_W'($urandom_range(0, 4095)));
        default: begin
          cell_id = ready_cells[$urandom_range(0, ready_cells.size() - 1)];
          if (cell_ready(cell_id)) begin
            ask(cell_id, rand_coef(), rand_coef(), rand_coef());
          end else begin
            send_reserved();
          end
        end
      endcase
    end

    drain();
    repeat (50) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("trilinear_cell_interpolator_core: match");
    end else begin
      $display("trilinear_cell_interpolator_core: mismatch");
    end
    $finish;
  end

endmodule
